@@ design/ivm_pkg.sv @@
// Package with shared types and constants for the interval value map.
package ivm_pkg;
   localparam int TableDepthDefault = 16;
   localparam int KeyBits = 32;
   localparam int ValueBits = 8;

   localparam logic CMD_ASSIGN = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef struct packed {
      logic                        cmd;
      logic signed [KeyBits-1:0]   range_begin;
      logic signed [KeyBits-1:0]   range_end;
      logic [ValueBits-1:0]        new_value;
      logic signed [KeyBits-1:0]   query_key;
   } req_type;

   typedef struct packed {
      logic [ValueBits-1:0] found_value;
      logic                 table_full;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_MOVE,
      ST_WRITE_NEW,
      ST_DONE
   } state_type;
endpackage

@@ design/interval_value_map_top.sv @@
// Top level of the interval value map: a sorted breakpoint table in memory.
//
// Usage: items arrive on the req_ channel (valid/ready) as one packed beat.
// A lookup beat (cmd = 1) returns the value in effect at query_key. An
// assign beat (cmd = 0) gives [range_begin, range_end) the value new_value
// and returns found_value 0, with table_full set if the table lacked room.
// Every accepted beat produces exactly one rsp_ beat.
// The default value below the first breakpoint is set through csr_wr_en and
// csr_wr_data while the block is idle; the user, not the block, ensures it.
// The scan reads one table entry per cycle, and a lookup answers once it
// has covered every entry. An assign then rewrites the table in a second
// pass of one entry per cycle, paused while the new pair is written.
// One item is in work at a time; the result waits in the output register
// while the receiver stalls, and the next beat is taken only after the
// result beat leaves and the block has gone from its done state to idle.
// Reset empties the table (entry count zero) and clears the default value;
// the memory contents need no clearing since entries past the count are
// never read.
module interval_value_map_top
   #(
      parameter int TABLE_DEPTH = ivm_pkg::TableDepthDefault
   )
   (
      input  logic             clock,
      input  logic             reset,
      input  logic             req_valid,
      output logic             req_ready,
      input  ivm_pkg::req_type req_data,
      output logic             rsp_valid,
      input  logic             rsp_ready,
      output ivm_pkg::rsp_type rsp_data,
      input  logic             csr_wr_en,
      input  logic [7:0]       csr_wr_data
   );
   import ivm_pkg::*;

   localparam int IdxBits = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CntBits = $clog2(TABLE_DEPTH + 1);
   localparam int AccBits = CntBits + 1;

   // Two copies of the table: the active bank is read, and an assign builds
   // its result in the other bank, then flips the bank select.
   logic [KeyBits-1:0]   key_mem [2][TABLE_DEPTH];
   logic [ValueBits-1:0] val_mem [2][TABLE_DEPTH];

   state_type            state_ff, state_in;
   req_type              item_ff;
   logic [ValueBits-1:0] default_ff;
   logic [CntBits-1:0]   count_ff, count_in;
   logic                 bank_ff, bank_in;
   logic [CntBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic                 rd_live_ff, rd_live_in;
   logic [KeyBits-1:0]   rd_key_ff;
   logic [ValueBits-1:0] rd_val_ff;
   logic [ValueBits-1:0] at_val_ff, at_val_in;   // value at query or range end
   logic [CntBits-1:0]   below_ff, below_in;
   logic [CntBits-1:0]   above_ff, above_in;
   logic [CntBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic                 new_pair_ff, new_pair_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   logic                 wr_en;
   logic [IdxBits-1:0]   wr_idx;
   logic [KeyBits-1:0]   wr_key;
   logic [ValueBits-1:0] wr_val;
   logic                 set_rsp;
   rsp_type              rsp_new;

   // Signed order compare via flipped sign bits.
   function automatic logic [KeyBits-1:0] ord(input logic [KeyBits-1:0] k);
      ord = k ^ {1'b1, {(KeyBits-1){1'b0}}};
   endfunction

   logic [KeyBits-1:0] scan_key;
   logic [KeyBits-1:0] o_rd, o_b, o_e;
   logic [AccBits-1:0] need;
   assign scan_key = (item_ff.cmd == CMD_LOOKUP) ? item_ff.query_key : item_ff.range_end;
   assign o_rd = ord(rd_key_ff);
   assign o_b  = ord(item_ff.range_begin);
   assign o_e  = ord(item_ff.range_end);
   assign need = AccBits'(below_ff) + AccBits'(above_ff) + AccBits'(2);

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      bank_in     = bank_ff;
      rd_ptr_in   = rd_ptr_ff;
      rd_live_in  = 1'b0;
      at_val_in   = at_val_ff;
      below_in    = below_ff;
      above_in    = above_ff;
      wr_ptr_in   = wr_ptr_ff;
      new_pair_in = new_pair_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               rd_ptr_in = '0;
               at_val_in = default_ff;
               below_in  = '0;
               above_in  = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Entry read issued last cycle arrives now in rd_key_ff.
            if (rd_live_ff) begin
               if (o_rd <= ord(scan_key)) at_val_in = rd_val_ff;
               if (o_rd < o_b) below_in = below_ff + 1'b1;
               else if (o_rd > o_e) above_in = above_ff + 1'b1;
            end
            if (rd_ptr_ff < count_ff) begin
               rd_live_in = 1'b1;
               rd_ptr_in  = rd_ptr_ff + 1'b1;
            end else if (!rd_live_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (item_ff.cmd == CMD_LOOKUP || o_b >= o_e
                || need > AccBits'(TABLE_DEPTH)) begin
               state_in = ST_DONE;
            end else begin
               rd_ptr_in   = '0;
               wr_ptr_in   = '0;
               new_pair_in = 1'b0;
               state_in    = ST_MOVE;
            end
         end
         ST_MOVE: begin
            // Copy kept entries into the other bank, inserting the new pair.
            if (rd_live_ff) begin
               if (o_rd < o_b || o_rd > o_e) wr_ptr_in = wr_ptr_ff + 1'b1;
            end
            if (rd_live_ff && o_rd > o_e && !new_pair_ff) begin
               // Insert the pair before this entry, then replay it.
               state_in  = ST_WRITE_NEW;
               wr_ptr_in = wr_ptr_ff;
               rd_ptr_in = rd_ptr_ff - 1'b1;
            end else if (rd_ptr_ff < count_ff) begin
               rd_live_in = 1'b1;
               rd_ptr_in  = rd_ptr_ff + 1'b1;
            end else if (!rd_live_ff) begin
               if (!new_pair_ff) state_in = ST_WRITE_NEW;
               else begin
                  count_in = wr_ptr_ff;
                  bank_in  = !bank_ff;
                  state_in = ST_DONE;
               end
            end
         end
         ST_WRITE_NEW: begin
            if (!new_pair_ff) begin
               wr_ptr_in = wr_ptr_ff + 1'b1;
               new_pair_in = 1'b1;
            end else begin
               wr_ptr_in = wr_ptr_ff + 1'b1;
               state_in  = ST_MOVE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Write port into the spare bank, and result formation.
   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = wr_ptr_ff[IdxBits-1:0];
      wr_key  = rd_key_ff;
      wr_val  = rd_val_ff;
      set_rsp = 1'b0;
      rsp_new = '0;
      case (state_ff)
         ST_MOVE: begin
            wr_en = rd_live_ff && (o_rd < o_b || (o_rd > o_e && new_pair_ff));
         end
         ST_WRITE_NEW: begin
            wr_en  = 1'b1;
            wr_key = new_pair_ff ? item_ff.range_end : item_ff.range_begin;
            wr_val = new_pair_ff ? at_val_ff : item_ff.new_value;
         end
         ST_DECIDE: begin
            if (item_ff.cmd == CMD_LOOKUP) begin
               set_rsp = 1'b1;
               rsp_new.found_value = at_val_ff;
            end else if (o_b >= o_e) begin
               set_rsp = 1'b1;
            end else if (need > AccBits'(TABLE_DEPTH)) begin
               set_rsp = 1'b1;
               rsp_new.table_full = 1'b1;
            end
         end
         default: ;
      endcase
      if (state_ff == ST_MOVE && state_in == ST_DONE) set_rsp = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (rd_live_in) begin
         rd_key_ff <= key_mem[bank_ff][rd_ptr_ff[IdxBits-1:0]];
         rd_val_ff <= val_mem[bank_ff][rd_ptr_ff[IdxBits-1:0]];
      end
      if (wr_en) begin
         key_mem[!bank_ff][wr_idx] <= wr_key;
         val_mem[!bank_ff][wr_idx] <= wr_val;
      end
      if (req_valid && req_ready) item_ff <= req_data;
      if (set_rsp) rsp_ff <= rsp_new;
      at_val_ff   <= at_val_in;
      below_ff    <= below_in;
      above_ff    <= above_in;
      wr_ptr_ff   <= wr_ptr_in;
      rd_ptr_ff   <= rd_ptr_in;
      new_pair_ff <= new_pair_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         bank_ff      <= 1'b0;
         rd_live_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         default_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         bank_ff    <= bank_in;
         rd_live_ff <= rd_live_in;
         if (csr_wr_en) default_ff <= csr_wr_data;
         if (set_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // The table never holds more entries than it has room for.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntBits'(TABLE_DEPTH))
      else $error("entry count exceeds table depth");
   // A new item is never taken while a result is still pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready)
      else $error("input accepted with a result pending");
   // The bank flips only when an assign completes.
   assert property (@(posedge clock) disable iff (reset)
      (bank_ff != $past(bank_ff)) |-> rsp_valid_ff)
      else $error("bank flipped without a result");
endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the interval value map: ranged writes and key reads.
`timescale 1ns / 1ps

module tb;
   import ivm_pkg::*;

   localparam int Depth = 16;
   localparam int StallLimit = 20000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_wr_en;
   logic [7:0] csr_wr_data;

   interval_value_map_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // Our own copy of the breakpoint table. Keys are kept signed so that the
   // ordinary comparison operators give the table's ordering.
   logic signed [KeyBits-1:0] bp_key[Depth];
   logic [ValueBits-1:0] bp_val[Depth];
   int bp_count;
   logic [ValueBits-1:0] base_value;

   req_type pending_beats[$];
   rsp_type expected_rsps[$];

   int errors = 0;
   int lookups_sent = 0;
   int assigns_sent = 0;
   int refusals_seen = 0;
   int idle_cycles = 0;
   bit rsp_holdoff = 0;
   int holdoff_left = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Value in effect at a key: the last breakpoint at or below it, else the
   // default.
   function automatic logic [ValueBits-1:0] value_at_key(logic signed [KeyBits-1:0] k);
      logic [ValueBits-1:0] v;
      v = base_value;
      for (int i = 0; i < bp_count; i++) begin
         if (bp_key[i] <= k) v = bp_val[i];
         else break;
      end
      return v;
   endfunction

   // Applies one beat to the table copy and returns the response it yields.
   function automatic rsp_type apply_beat(req_type r);
      rsp_type o;
      logic signed [KeyBits-1:0] nk[Depth];
      logic [ValueBits-1:0] nv[Depth];
      logic [ValueBits-1:0] tail_val;
      int below, above, n;
      o = '0;
      below = 0;
      above = 0;
      n = 0;
      if (r.cmd == CMD_LOOKUP) begin
         o.found_value = value_at_key(r.query_key);
         return o;
      end
      if (r.range_begin >= r.range_end) return o;
      for (int i = 0; i < bp_count; i++) begin
         if (bp_key[i] < r.range_begin) below++;
         else if (bp_key[i] > r.range_end) above++;
      end
      if (below + 2 + above > Depth) begin
         o.table_full = 1'b1;
         return o;
      end
      tail_val = value_at_key(r.range_end);
      for (int i = 0; i < below; i++) begin
         nk[n] = bp_key[i];
         nv[n] = bp_val[i];
         n++;
      end
      nk[n] = r.range_begin;
      nv[n] = r.new_value;
      n++;
      nk[n] = r.range_end;
      nv[n] = tail_val;
      n++;
      for (int i = 0; i < bp_count; i++) begin
         if (bp_key[i] > r.range_end) begin
            nk[n] = bp_key[i];
            nv[n] = bp_val[i];
            n++;
         end
      end
      for (int i = 0; i < n; i++) begin
         bp_key[i] = nk[i];
         bp_val[i] = nv[i];
      end
      bp_count = n;
      return o;
   endfunction

   // The handshake is sampled at the rising edge so the driver knows at the
   // next falling edge whether the beat on the wires went through.
   logic req_ready_seen;

   // Driver: offers the oldest pending beat, with random gaps between beats.
   // Valid stays up with a steady payload until the beat is taken.
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready_seen) begin
         // Hold the current beat.
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
         req_data <= pending_beats.pop_front();
         req_valid <= 1'b1;
         gap_left <= pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(posedge clock) begin
      req_ready_seen <= req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         expected_rsps.push_back(apply_beat(req_data));
         if (req_data.cmd == CMD_LOOKUP) lookups_sent++;
         else assigns_sent++;
      end
   end

   // Most gaps are zero or short; a few are long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver readiness: random stalls, plus a long forced hold-off that the
   // stimulus process can request to fill the block and stall its input.
   int stall_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_holdoff) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < 25) stall_left <= pick_gap();
      end
   end

   // Hold-off counter in its own process, counted in cycles.
   always @(posedge clock) begin
      if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
         if (holdoff_left == 1) rsp_holdoff <= 1'b0;
      end
   end

   // Monitor: every response beat is checked against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: response with nothing expected, actual %h", $realtime, rsp_data);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (want.table_full) refusals_seen++;
            if (rsp_data.found_value !== want.found_value) begin
               $display("%0t: found_value mismatch, expected %h actual %h",
                        $realtime, want.found_value, rsp_data.found_value);
               errors++;
            end
            if (rsp_data.table_full !== want.table_full) begin
               $display("%0t: table_full mismatch, expected %b actual %b",
                        $realtime, want.table_full, rsp_data.table_full);
               errors++;
            end
         end
      end
   end

   // Watchdog: counts cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("Watchdog expired with %0d responses outstanding", expected_rsps.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Keys come mostly from a small window so ranges overlap and the table
   // fills, with occasional extremes of the full signed range.
   function automatic logic signed [KeyBits-1:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $signed($urandom_range(0, 80)) - 40;
      if (roll < 85) return 32'sh7fffffff - $urandom_range(0, 3);
      if (roll < 90) return 32'sh80000000 + $urandom_range(0, 3);
      return $signed($urandom());
   endfunction

   function automatic req_type make_assign(logic signed [KeyBits-1:0] b,
                                           logic signed [KeyBits-1:0] e,
                                           logic [ValueBits-1:0] v);
      req_type r;
      r.cmd = CMD_ASSIGN;
      r.range_begin = b;
      r.range_end = e;
      r.new_value = v;
      r.query_key = $signed($urandom());
      return r;
   endfunction

   function automatic req_type make_lookup(logic signed [KeyBits-1:0] k);
      req_type r;
      r.cmd = CMD_LOOKUP;
      r.range_begin = $signed($urandom());
      r.range_end = $signed($urandom());
      r.new_value = ValueBits'($urandom());
      r.query_key = k;
      return r;
   endfunction

   function automatic req_type random_beat();
      logic signed [KeyBits-1:0] a, b;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return make_lookup(pick_key());
      a = pick_key();
      b = pick_key();
      // Mostly well-ordered ranges; some empty or reversed ones stay in.
      if (roll < 92 && a > b) return make_assign(b, a, ValueBits'($urandom()));
      return make_assign(a, b, ValueBits'($urandom()));
   endfunction

   // Waits until the block has drained every outstanding beat, then lets
   // a full assign's worth of cycles pass so it is back in its idle state.
   // Checked at the rising edge, where a beat handed to the wires shows as
   // valid and a taken one already has its expectation queued.
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_beats.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_default(logic [7:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      base_value = v;
   endtask

   initial begin
      logic [7:0] settings[4];
      settings = '{8'h00, 8'hff, 8'h5a, 8'ha5};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      bp_count = 0;
      base_value = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty-table lookups at the key extremes, empty and reversed
      // ranges, full-range extremes, then filling until an assign is refused.
      pending_beats.push_back(make_lookup(32'sh80000000));
      pending_beats.push_back(make_lookup(32'sh7fffffff));
      pending_beats.push_back(make_assign(5, 5, 8'hff));
      pending_beats.push_back(make_assign(9, 3, 8'h11));
      pending_beats.push_back(make_assign(32'sh80000000, 32'sh7fffffff, 8'hff));
      pending_beats.push_back(make_lookup(32'sh80000000));
      pending_beats.push_back(make_lookup(32'sh7fffffff));
      pending_beats.push_back(make_assign(-10, 10, 8'h00));
      pending_beats.push_back(make_lookup(-11));
      pending_beats.push_back(make_lookup(9));
      pending_beats.push_back(make_lookup(10));
      for (int i = 0; i < 9; i++)
         pending_beats.push_back(make_assign(100 + 4 * i, 102 + 4 * i, 8'(i + 1)));
      pending_beats.push_back(make_lookup(101));
      pending_beats.push_back(make_lookup(136));
      pending_beats.push_back(make_assign(-20, 0, 8'h77));
      wait_drained();

      // Hold the receiver off long enough to stall the input with beats
      // still queued at the driver.
      for (int i = 0; i < 30; i++) pending_beats.push_back(random_beat());
      rsp_holdoff = 1'b1;
      holdoff_left = 300;
      wait_drained();

      // Random phases, one per default setting, the table reset by a full
      // wipe so that refusals and fresh tables both recur.
      for (int p = 0; p < 4; p++) begin
         write_default(settings[p]);
         pending_beats.push_back(make_assign(32'sh80000000, 32'sh7fffffff,
                                             ValueBits'($urandom())));
         for (int i = 0; i < 375; i++) pending_beats.push_back(random_beat());
         wait_drained();
      end

      $display("Covered %0d lookups and %0d assigns, %0d of them refused for lack of room,",
               lookups_sent, assigns_sent, refusals_seen);
      $display("over four default settings including both extremes.");
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
